/* rtl/imu_record_decode_calibrate_core_macros.svh */
// assertion macros shared by the imu record decoder rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef IMU_RECORD_DECODE_CALIBRATE_CORE_MACROS_SVH
`define IMU_RECORD_DECODE_CALIBRATE_CORE_MACROS_SVH

// same-cycle implication
`define IMU_RDC_CHECK_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IMU_RDC_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/imu_rdc_pkg.sv */
// shared types and constants for the imu record decoder
// used by imu_rdc_seq and imu_record_decode_calibrate_core, no dependencies
package imu_rdc_pkg;

    localparam int RECORD_BYTES = 16;
    localparam int POS_W        = $clog2(RECORD_BYTES);
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 48;
    localparam int TIME_W       = 58;
    localparam int PC_W         = 3;
    localparam int CNT_W        = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LSB_SCALE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_LSB_SCALE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_OFFSETS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_INV_SCALES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIASES      = 3'd4;

    // datapath operations issued by the sequencer
    typedef enum logic [2:0] {
        OP_NOP          = 3'd0,
        OP_MUL_RAW_ALSB = 3'd1,
        OP_MUL_RAW_GLSB = 3'd2,
        OP_SUB_OFFSET   = 3'd3,
        OP_MUL_ACC_INV  = 3'd4,
        OP_WR_ACCEL     = 3'd5,
        OP_WR_GYRO      = 3'd6,
        OP_DIV_STEP     = 3'd7
    } op_t;

    // one microcode word
    typedef struct packed {
        op_t              op;
        logic             loop_en;
        logic [CNT_W-1:0] loop_last;
        logic [PC_W-1:0]  loop_target;
        logic             done;
    } ucode_t;

    // sequencer to datapath control
    typedef struct packed {
        op_t        op;
        logic [1:0] axis;
        logic       done;
        logic       busy;
    } ctrl_t;

endpackage

/* rtl/imu_rdc_seq.sv */
// microcode sequencer: program table, step counter and loop counter
// depends on imu_rdc_pkg and the shared assertion macro header
`include "imu_record_decode_calibrate_core_macros.svh"

module imu_rdc_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output imu_rdc_pkg::ctrl_t  ctrl
);
    import imu_rdc_pkg::*;

    logic             busy_reg, busy_next;
    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    ucode_t           uw;

    // program: accel loop, gyro loop, nibble divide loop, finish
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{op: OP_NOP, loop_en: 1'b0, loop_last: '0, loop_target: '0, done: 1'b0};
        case (pc)
            3'd0: w.op = OP_MUL_RAW_ALSB;
            3'd1: w.op = OP_SUB_OFFSET;
            3'd2: w.op = OP_MUL_ACC_INV;
            3'd3:
            begin
                w.op          = OP_WR_ACCEL;
                w.loop_en     = 1'b1;
                w.loop_last   = 4'd2;
                w.loop_target = 3'd0;
            end
            3'd4: w.op = OP_MUL_RAW_GLSB;
            3'd5:
            begin
                w.op          = OP_WR_GYRO;
                w.loop_en     = 1'b1;
                w.loop_last   = 4'd2;
                w.loop_target = 3'd4;
            end
            3'd6:
            begin
                w.op          = OP_DIV_STEP;
                w.loop_en     = 1'b1;
                w.loop_last   = 4'd15;
                w.loop_target = 3'd6;
            end
            default: w.done = 1'b1;
        endcase
        return w;
    endfunction

    assign uw = ucode_rom(pc_reg);

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            pc_next   = '0;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            if (uw.done)
            begin
                busy_next = 1'b0;
                pc_next   = '0;
            end
            else if (uw.loop_en && cnt_reg != uw.loop_last)
            begin
                cnt_next = CNT_W'(cnt_reg + 1'b1);
                pc_next  = uw.loop_target;
            end
            else
            begin
                // apart from start, the loop counter only clears when its loop is left
                if (uw.loop_en)
                    cnt_next = '0;
                pc_next  = PC_W'(pc_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign ctrl.op   = busy_reg ? uw.op : OP_NOP;
    assign ctrl.axis = cnt_reg[1:0];
    assign ctrl.done = busy_reg & uw.done;
    assign ctrl.busy = busy_reg;

    `IMU_RDC_CHECK_NOW(a_start_only_idle, start, !busy_reg, "record started during a run")
    `IMU_RDC_CHECK_NEXT(a_done_ends_run, busy_reg && uw.done, !busy_reg, "run did not end")
    `IMU_RDC_CHECK_NOW(a_loop_count_bounded, busy_reg && uw.loop_en,
        cnt_reg <= uw.loop_last, "loop counter past its limit")

endmodule

/* rtl/imu_record_decode_calibrate_core.sv */
// imu record decoder with offset, bias and scale calibration, top level
// depends on imu_rdc_pkg, imu_rdc_seq and the shared assertion macro header
//
// Bytes of 16-byte records are taken one per cycle while in_stall is low.
// The last byte of a record that is not all zero starts a microcode run
// (three accel axes at four steps, three gyro axes at two steps, sixteen
// nibble steps of the divide by 15, one finish step) on a single shared
// 34x25 multiplier; input is stalled for the run. The result sits in the
// output registers until taken; bytes of the next record keep flowing
// meanwhile, only its last byte waits for the output to be free. No
// clearing pass follows reset.
`include "imu_record_decode_calibrate_core_macros.svh"

module imu_record_decode_calibrate_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [imu_rdc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [imu_rdc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          data_byte,
    input  logic                                record_start,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [31:0]                  accel_x,
    output logic signed [31:0]                  accel_y,
    output logic signed [31:0]                  accel_z,
    output logic signed [31:0]                  gyro_x,
    output logic signed [31:0]                  gyro_y,
    output logic signed [31:0]                  gyro_z,
    output logic [imu_rdc_pkg::TIME_W-1:0]      time_us
);
    import imu_rdc_pkg::*;

    localparam logic [23:0] ACCEL_LSB_RST = 24'd1024;
    localparam logic [23:0] GYRO_LSB_RST  = 24'd1023000;
    localparam logic [47:0] INV_SCALE_RST = 48'h4000_4000_4000;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(RECORD_BYTES - 1);
    // ticks / 120 = (ticks >> 3) / 15, quotient digit of v < 240 is (v * 137) >> 11
    localparam int TICK_SHIFT   = 3;
    localparam logic [7:0]  TICK_ODD = 8'd15;
    localparam logic [14:0] RECIP_15 = 15'd137;
    localparam int RECIP_SHIFT  = 11;

    // configuration
    logic [23:0] accel_lsb_reg, gyro_lsb_reg;
    logic [47:0] accel_off_reg, accel_inv_reg, gyro_bias_reg;

    // record framing
    logic [POS_W-1:0] byte_pos_reg, pos;
    logic             nz_reg, nz_next;
    logic [7:0]       rec_reg [RECORD_BYTES-1];
    logic [31:0]      prev_ticks_reg, wrap_reg, wrap_next, ticks;
    logic             in_accept, is_last, start;

    // datapath
    ctrl_t              ctrl;
    logic [47:0]        accel_raw_reg, gyro_raw_reg;
    logic [95:0]        accel_out_reg, gyro_out_reg;
    logic signed [33:0] mul_a, acc_reg;
    logic signed [24:0] mul_b;
    logic               is_mul;
    logic signed [58:0] prod_reg;
    logic signed [50:0] rnd8, rnd14, gyro_sum;
    logic [15:0]        off_k, inv_k, bias_k;
    logic [63:0]        div_reg;
    logic [3:0]         rem_reg, div_q, div_r;
    logic [7:0]         div_v, div_rem8;
    logic [14:0]        div_qp;
    logic               out_valid_reg;

    function automatic logic [15:0] pick16(input logic [47:0] v, input logic [1:0] k);
        logic [15:0] f;
        case (k)
            2'd0:    f = v[15:0];
            2'd1:    f = v[31:16];
            default: f = v[47:32];
        endcase
        return f;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [50:0] v);
        logic [31:0] r;
        if (v > 51'sd2147483647)
            r = 32'h7fff_ffff;
        else if (v < -51'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // ---------------- input framing ----------------
    assign pos       = record_start ? '0 : byte_pos_reg;
    assign is_last   = (pos == LAST_POS);
    assign in_stall  = ctrl.busy | (out_valid_reg & is_last);
    assign in_accept = in_valid & ~in_stall;
    assign nz_next   = (pos == '0) ? (data_byte != 8'd0) : (nz_reg | (data_byte != 8'd0));
    assign start     = in_accept & is_last & nz_next;
    assign ticks     = {rec_reg[12], rec_reg[13], rec_reg[14], data_byte};
    assign wrap_next = (ticks < prev_ticks_reg) ? 32'(wrap_reg + 1'b1) : wrap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_lsb_reg  <= ACCEL_LSB_RST;
            gyro_lsb_reg   <= GYRO_LSB_RST;
            accel_off_reg  <= '0;
            accel_inv_reg  <= INV_SCALE_RST;
            gyro_bias_reg  <= '0;
            byte_pos_reg   <= '0;
            nz_reg         <= 1'b0;
            prev_ticks_reg <= '0;
            wrap_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ACCEL_LSB_SCALE:  accel_lsb_reg <= cfg_data[23:0];
                    REG_GYRO_LSB_SCALE:   gyro_lsb_reg  <= cfg_data[23:0];
                    REG_ACCEL_OFFSETS:    accel_off_reg <= cfg_data;
                    REG_ACCEL_INV_SCALES: accel_inv_reg <= cfg_data;
                    REG_GYRO_BIASES:      gyro_bias_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (in_accept)
            begin
                nz_reg       <= nz_next;
                byte_pos_reg <= is_last ? '0 : POS_W'(pos + 1'b1);
            end
            if (start)
            begin
                prev_ticks_reg <= ticks;
                wrap_reg       <= wrap_next;
            end
            if (ctrl.done)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // bytes 0..14 arrive in order, so a shift line holds them when byte 15 comes
    always_ff @(posedge clk)
    begin
        if (in_accept && !is_last)
        begin
            for (int i = 0; i < RECORD_BYTES - 2; i++)
                rec_reg[i] <= rec_reg[i + 1];
            rec_reg[RECORD_BYTES - 2] <= data_byte;
        end
    end

    // ---------------- microcode sequencer ----------------
    imu_rdc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .ctrl  (ctrl)
    );

    // ---------------- shared arithmetic ----------------
    assign off_k  = pick16(accel_off_reg, ctrl.axis);
    assign inv_k  = pick16(accel_inv_reg, ctrl.axis);
    assign bias_k = pick16(gyro_bias_reg, ctrl.axis);

    always_comb
    begin
        mul_a  = acc_reg;
        mul_b  = signed'({9'd0, inv_k});
        is_mul = 1'b0;
        case (ctrl.op)
            OP_MUL_RAW_ALSB:
            begin
                mul_a  = 34'(signed'(accel_raw_reg[15:0]));
                mul_b  = signed'({1'b0, accel_lsb_reg});
                is_mul = 1'b1;
            end
            OP_MUL_RAW_GLSB:
            begin
                mul_a  = 34'(signed'(gyro_raw_reg[15:0]));
                mul_b  = signed'({1'b0, gyro_lsb_reg});
                is_mul = 1'b1;
            end
            OP_MUL_ACC_INV: is_mul = 1'b1;
            default: ;
        endcase
    end

    // round half up: add half an lsb, arithmetic shift
    assign rnd8     = 51'((prod_reg + 59'sd128) >>> 8);
    assign rnd14    = 51'((prod_reg + 59'sd8192) >>> 14);
    assign gyro_sum = rnd8 + (51'(signed'(bias_k)) <<< 8);

    // divide by 15 one nibble a step, quotient shifts in from the bottom
    assign div_v    = {rem_reg, div_reg[63:60]};
    assign div_qp   = 15'(div_v) * RECIP_15;
    assign div_q    = div_qp[14:RECIP_SHIFT];
    assign div_rem8 = div_v - 8'({4'd0, div_q} * TICK_ODD);
    assign div_r    = div_rem8[3:0];

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            accel_raw_reg <= {rec_reg[4], rec_reg[5], rec_reg[2], rec_reg[3],
                              rec_reg[0], rec_reg[1]};
            gyro_raw_reg  <= {rec_reg[10], rec_reg[11], rec_reg[8], rec_reg[9],
                              rec_reg[6], rec_reg[7]};
            div_reg       <= {{TICK_SHIFT{1'b0}}, wrap_next, ticks[31:TICK_SHIFT]};
            rem_reg       <= '0;
        end
        if (is_mul)
            prod_reg <= mul_a * mul_b;
        case (ctrl.op)
            OP_SUB_OFFSET: acc_reg <= 34'(rnd8) - 34'(signed'(off_k));
            OP_WR_ACCEL:
            begin
                accel_out_reg <= {sat32(rnd14), accel_out_reg[95:32]};
                accel_raw_reg <= {16'd0, accel_raw_reg[47:16]};
            end
            OP_WR_GYRO:
            begin
                gyro_out_reg <= {sat32(gyro_sum), gyro_out_reg[95:32]};
                gyro_raw_reg <= {16'd0, gyro_raw_reg[47:16]};
            end
            OP_DIV_STEP:
            begin
                div_reg <= {div_reg[59:0], div_q};
                rem_reg <= div_r;
            end
            default: ;
        endcase
    end

    // ---------------- result word ----------------
    assign out_valid = out_valid_reg;
    assign accel_x   = accel_out_reg[31:0];
    assign accel_y   = accel_out_reg[63:32];
    assign accel_z   = accel_out_reg[95:64];
    assign gyro_x    = gyro_out_reg[31:0];
    assign gyro_y    = gyro_out_reg[63:32];
    assign gyro_z    = gyro_out_reg[95:64];
    assign time_us   = div_reg[TIME_W-1:0];

    `IMU_RDC_CHECK_NOW(a_no_word_during_run, in_valid && !in_stall, !ctrl.busy,
        "input word taken during a run")
    `IMU_RDC_CHECK_NOW(a_start_output_free, start, !out_valid_reg,
        "run started while a result still waits")
    `IMU_RDC_CHECK_NEXT(a_done_presents_result, ctrl.done, out_valid_reg,
        "finished run did not present a result")

endmodule
